### src/rzor_pkg.sv
// ----------------------------------------------------------------------------
// rzor_pkg
// Shared types, widths and register codes for the robust outlier replacer.
// ----------------------------------------------------------------------------
package rzor_pkg;

    localparam int NUM_SENSORS = 4;
    localparam int LOG2_N      = 2;
    localparam int SAMPLE_W    = 24;
    localparam int WIDE_W      = 28;   // signed, two extra fraction bits plus headroom
    localparam int DEV_W       = 27;   // unsigned absolute deviation, units of 2^-2
    localparam int PROD_W      = 28;   // threshold times scale
    localparam int BOUND_W     = PROD_W + DEV_W;
    localparam int PIPE_DEPTH  = 7;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [WIDE_W-1:0]   wide_t;
    typedef logic        [DEV_W-1:0]    dev_t;

    typedef enum logic [1:0] {
        REG_THRESHOLD  = 2'd0,
        REG_MEDIAN_DEV = 2'd1,
        REG_MEAN_DEV   = 2'd2,
        REG_NONE       = 2'd3
    } reg_index_t;

endpackage

### src/rzor_median4.sv
// ----------------------------------------------------------------------------
// rzor_median4
// Sorting network over four values; returns the sum of the middle two.
// ----------------------------------------------------------------------------
module rzor_median4 (
    input  rzor_pkg::wide_t            v0,
    input  rzor_pkg::wide_t            v1,
    input  rzor_pkg::wide_t            v2,
    input  rzor_pkg::wide_t            v3,
    output logic signed [rzor_pkg::WIDE_W:0] mid_sum
);
    import rzor_pkg::*;

    wide_t a0, a1, a2, a3;
    wide_t b0, b1, b2, b3;
    wide_t c1, c2;

    always_comb
    begin
        a0 = (v0 < v1) ? v0 : v1;
        a1 = (v0 < v1) ? v1 : v0;
        a2 = (v2 < v3) ? v2 : v3;
        a3 = (v2 < v3) ? v3 : v2;
        b0 = (a0 < a2) ? a0 : a2;
        b2 = (a0 < a2) ? a2 : a0;
        b1 = (a1 < a3) ? a1 : a3;
        b3 = (a1 < a3) ? a3 : a1;
        c1 = (b1 < b2) ? b1 : b2;
        c2 = (b1 < b2) ? b2 : b1;
        // extremes only feed the sort
        mid_sum = WIDE_W'(0) + {c1[WIDE_W-1], c1} + {c2[WIDE_W-1], c2}
                  + ((b0 > b3) ? (WIDE_W+1)'(1) : (WIDE_W+1)'(0));
    end

endmodule

### src/rzor_lane.sv
// ----------------------------------------------------------------------------
// rzor_lane
// Per-sensor deviation unit: distance of one reading from median and mean.
// ----------------------------------------------------------------------------
module rzor_lane (
    input  rzor_pkg::sample_t x,
    input  rzor_pkg::wide_t   med4,
    input  rzor_pkg::wide_t   mean4,
    output rzor_pkg::dev_t    dev_med,
    output rzor_pkg::dev_t    dev_mean
);
    import rzor_pkg::*;

    wide_t x4;
    wide_t d;
    wide_t e;

    always_comb
    begin
        x4 = {{(WIDE_W-SAMPLE_W-2){x[SAMPLE_W-1]}}, x, 2'b00};
        d  = x4 - med4;
        e  = x4 - mean4;
        dev_med  = d[WIDE_W-1] ? DEV_W'(-d) : DEV_W'(d);
        dev_mean = e[WIDE_W-1] ? DEV_W'(-e) : DEV_W'(e);
    end

endmodule

### src/robust_zscore_outlier_replace.sv
// ----------------------------------------------------------------------------
// robust_zscore_outlier_replace
// Median / MAD outlier replacement across four redundant sensor readings.
// ----------------------------------------------------------------------------
// A sensor vector is accepted every cycle (busy stays low) and its result
// appears on the result ports for one cycle with done high. The pipeline
// runs: input register, median and sum, per-lane deviations, MAD and mean
// deviation, bound multiply, compare and replace, then the averaging output
// register. Results cannot be held off.
// Configuration must only change while no vector is in flight.
module robust_zscore_outlier_replace (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  rzor_pkg::sample_t       sample_0,
    input  rzor_pkg::sample_t       sample_1,
    input  rzor_pkg::sample_t       sample_2,
    input  rzor_pkg::sample_t       sample_3,
    output logic                    done,
    output rzor_pkg::sample_t       cleaned_0,
    output rzor_pkg::sample_t       cleaned_1,
    output rzor_pkg::sample_t       cleaned_2,
    output rzor_pkg::sample_t       cleaned_3,
    output rzor_pkg::sample_t       fused_average,
    output logic [3:0]              reliable_mask,
    output logic [3:0]              replaced_mask,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import rzor_pkg::*;

    localparam int N = NUM_SENSORS;

    // configuration
    logic [11:0] thr_reg;
    logic [15:0] mds_reg;
    logic [15:0] mns_reg;
    reg_index_t  widx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign widx   = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 12'd896;
            mds_reg <= 16'd6087;
            mns_reg <= 16'd5134;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (widx)
                REG_THRESHOLD:  thr_reg <= pwdata[11:0];
                REG_MEDIAN_DEV: mds_reg <= pwdata[15:0];
                REG_MEAN_DEV:   mns_reg <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            REG_THRESHOLD:  prdata = {20'd0, thr_reg};
            REG_MEDIAN_DEV: prdata = {16'd0, mds_reg};
            REG_MEAN_DEV:   prdata = {16'd0, mns_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // threshold times scale, static between writes
    logic [PROD_W-1:0] kmed_reg;
    logic [PROD_W-1:0] kmean_reg;

    always_ff @(posedge clk)
    begin
        kmed_reg  <= PROD_W'(thr_reg) * PROD_W'(mds_reg);
        kmean_reg <= PROD_W'(thr_reg) * PROD_W'(mns_reg);
    end

    logic [PIPE_DEPTH-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], start};
    end

    // stage 0: input register
    sample_t x0_reg [N];
    logic [N-1:0] rel0_reg;

    always_ff @(posedge clk)
    begin
        x0_reg[0] <= sample_0;
        x0_reg[1] <= sample_1;
        x0_reg[2] <= sample_2;
        x0_reg[3] <= sample_3;
        rel0_reg  <= {sample_3 != '0, sample_2 != '0, sample_1 != '0, sample_0 != '0};
    end

    // stage 1: median and mean
    logic signed [WIDE_W:0] smid;
    wide_t  sum_x;
    sample_t x1_reg [N];
    logic [N-1:0] rel1_reg;
    wide_t  med1_reg;
    wide_t  mean1_reg;

    rzor_median4 u_med_x (
        .v0      (WIDE_W'(x0_reg[0])),
        .v1      (WIDE_W'(x0_reg[1])),
        .v2      (WIDE_W'(x0_reg[2])),
        .v3      (WIDE_W'(x0_reg[3])),
        .mid_sum (smid)
    );

    always_comb
    begin
        sum_x = '0;
        for (int i = 0; i < N; i++)
            sum_x = sum_x + WIDE_W'(x0_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        x1_reg    <= x0_reg;
        rel1_reg  <= rel0_reg;
        med1_reg  <= {smid[WIDE_W-2:0], 1'b0};
        // floor(4*sum / 4) is the sum itself
        mean1_reg <= wide_t'((sum_x <<< 2) >>> LOG2_N);
    end

    // stage 2: per-lane deviations
    dev_t dm_c [N];
    dev_t de_c [N];
    dev_t dm2_reg [N];
    dev_t de2_reg [N];
    sample_t x2_reg [N];
    logic [N-1:0] rel2_reg;
    wide_t med2_reg;

    for (genvar g = 0; g < N; g++)
    begin : g_lane
        rzor_lane u_lane (
            .x        (x1_reg[g]),
            .med4     (med1_reg),
            .mean4    (mean1_reg),
            .dev_med  (dm_c[g]),
            .dev_mean (de_c[g])
        );
    end

    always_ff @(posedge clk)
    begin
        dm2_reg  <= dm_c;
        de2_reg  <= de_c;
        x2_reg   <= x1_reg;
        rel2_reg <= rel1_reg;
        med2_reg <= med1_reg;
    end

    // stage 3: mad and mean deviation
    logic signed [WIDE_W:0] dmid;
    logic [DEV_W+LOG2_N-1:0] dsum;
    dev_t mad3_reg;
    dev_t mnd3_reg;
    dev_t dm3_reg [N];
    sample_t x3_reg [N];
    logic [N-1:0] rel3_reg;
    wide_t med3_reg;

    rzor_median4 u_med_d (
        .v0      (WIDE_W'(dm2_reg[0])),
        .v1      (WIDE_W'(dm2_reg[1])),
        .v2      (WIDE_W'(dm2_reg[2])),
        .v3      (WIDE_W'(dm2_reg[3])),
        .mid_sum (dmid)
    );

    always_comb
    begin
        dsum = '0;
        for (int i = 0; i < N; i++)
            dsum = dsum + (DEV_W+LOG2_N)'(de2_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        mad3_reg <= dmid[DEV_W:1];
        mnd3_reg <= dsum[DEV_W+LOG2_N-1:LOG2_N];
        dm3_reg  <= dm2_reg;
        x3_reg   <= x2_reg;
        rel3_reg <= rel2_reg;
        med3_reg <= med2_reg;
    end

    // stage 4: bound
    logic [BOUND_W-1:0] bound4_reg;
    dev_t dm4_reg [N];
    sample_t x4_reg [N];
    logic [N-1:0] rel4_reg;
    wide_t med4_reg;

    always_ff @(posedge clk)
    begin
        if (mad3_reg != '0)
            bound4_reg <= BOUND_W'(kmed_reg) * BOUND_W'(mad3_reg);
        else
            bound4_reg <= BOUND_W'(kmean_reg) * BOUND_W'(mnd3_reg);
        dm4_reg  <= dm3_reg;
        x4_reg   <= x3_reg;
        rel4_reg <= rel3_reg;
        med4_reg <= med3_reg;
    end

    // stage 5: compare and replace
    sample_t med_q;
    sample_t cl5_reg [N];
    logic [N-1:0] rep5_reg;
    logic [N-1:0] rel5_reg;
    logic [N-1:0] rep_c;

    assign med_q = med4_reg[SAMPLE_W+1:2];

    always_comb
    begin
        for (int i = 0; i < N; i++)
            rep_c[i] = ({dm4_reg[i], 20'd0} > BOUND_W'(bound4_reg));
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
            cl5_reg[i] <= rep_c[i] ? med_q : x4_reg[i];
        rep5_reg <= rep_c;
        rel5_reg <= rel4_reg;
    end

    // stage 6: average and output
    logic signed [SAMPLE_W+LOG2_N-1:0] csum;
    sample_t cl6_reg [N];
    sample_t avg6_reg;
    logic [N-1:0] rep6_reg;
    logic [N-1:0] rel6_reg;

    always_comb
    begin
        csum = '0;
        for (int i = 0; i < N; i++)
            csum = csum + (SAMPLE_W+LOG2_N)'(cl5_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        cl6_reg  <= cl5_reg;
        avg6_reg <= csum[SAMPLE_W+LOG2_N-1:LOG2_N];
        rep6_reg <= rep5_reg;
        rel6_reg <= rel5_reg;
    end

    assign done          = vld_reg[PIPE_DEPTH-1];
    assign cleaned_0     = cl6_reg[0];
    assign cleaned_1     = cl6_reg[1];
    assign cleaned_2     = cl6_reg[2];
    assign cleaned_3     = cl6_reg[3];
    assign fused_average = avg6_reg;
    assign reliable_mask = rel6_reg;
    assign replaced_mask = rep6_reg;

endmodule

### tb/sv/robust_zscore_outlier_replace_tb.sv
// ----------------------------------------------------------------------------
// robust_zscore_outlier_replace_tb
// Self-checking bench: random and corner sensor vectors driven through the
// start/busy port, results checked against an in-bench predictor of the
// median / MAD replacement, across several register settings.
// ----------------------------------------------------------------------------
module robust_zscore_outlier_replace_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rzor_pkg::*;

    typedef struct packed {
        sample_t s0, s1, s2, s3;
    } vec_t;

    typedef struct packed {
        sample_t    c0, c1, c2, c3;
        sample_t    avg;
        logic [3:0] rel;
        logic [3:0] rep;
    } clean_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    sample_t     sample_0 = '0, sample_1 = '0, sample_2 = '0, sample_3 = '0;
    logic        done;
    sample_t     cleaned_0, cleaned_1, cleaned_2, cleaned_3, fused_average;
    logic [3:0]  reliable_mask, replaced_mask;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    robust_zscore_outlier_replace dut (.*);

    always #4 clk = ~clk;

    vec_t   pending_vecs[$];
    clean_t expected_results[$];
    logic [11:0] thr_q = 12'd896;
    logic [15:0] mad_scale_q = 16'd6087;
    logic [15:0] mean_scale_q = 16'd5134;
    int     errors = 0;
    int     checked = 0;
    int     sent = 0;
    longint cycles = 0;
    bit     hold_sender = 1'b0;

    function automatic longint floor_div4(longint n);
        longint q;
        q = n / 4;
        if ((n % 4) != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic clean_t predict_clean(vec_t v);
        longint x[4], s[4], d[4], t[4], tmp;
        longint sum, med4, mean4, dsum, meanad4, mad4, csum, cl, e;
        logic [63:0] bound, lhs;
        clean_t r;
        x[0] = v.s0; x[1] = v.s1; x[2] = v.s2; x[3] = v.s3;
        sum = 0; dsum = 0; csum = 0;
        r.rel = '0; r.rep = '0;
        for (int i = 0; i < 4; i++)
        begin
            s[i] = x[i];
            sum += x[i];
            if (x[i] != 0) r.rel[i] = 1'b1;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3 - i; j++)
                if (s[j] > s[j+1])
                begin
                    tmp = s[j]; s[j] = s[j+1]; s[j+1] = tmp;
                end
        med4 = (s[1] + s[2]) * 2;
        mean4 = floor_div4(sum * 4);
        for (int i = 0; i < 4; i++)
        begin
            d[i] = x[i] * 4 - med4;
            if (d[i] < 0) d[i] = -d[i];
            t[i] = d[i];
            e = x[i] * 4 - mean4;
            dsum += (e < 0) ? -e : e;
        end
        meanad4 = floor_div4(dsum);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3 - i; j++)
                if (t[j] > t[j+1])
                begin
                    tmp = t[j]; t[j] = t[j+1]; t[j+1] = tmp;
                end
        mad4 = (t[1] + t[2]) / 2;
        if (mad4 != 0)
            bound = 64'(thr_q) * 64'(mad_scale_q) * 64'(mad4);
        else
            bound = 64'(thr_q) * 64'(mean_scale_q) * 64'(meanad4);
        for (int i = 0; i < 4; i++)
        begin
            lhs = 64'(d[i]) << 20;
            if (lhs > bound)
            begin
                cl = floor_div4(med4);
                r.rep[i] = 1'b1;
            end
            else
                cl = x[i];
            csum += cl;
            case (i)
                0: r.c0 = sample_t'(cl);
                1: r.c1 = sample_t'(cl);
                2: r.c2 = sample_t'(cl);
                default: r.c3 = sample_t'(cl);
            endcase
        end
        r.avg = sample_t'(floor_div4(csum));
        return r;
    endfunction

    // driver: one beat per accepted vector, random gaps
    int gap = 0;
    always @(posedge clk)
    begin
        if (start && !busy)
        begin
            expected_results.push_back(predict_clean(pending_vecs.pop_front()));
            sent++;
            gap = $urandom_range(0, 3);
            if ($urandom_range(0, 2) == 0) gap = 0;
        end
        if (start && busy)
            ;
        else if (gap > 0)
        begin
            gap--;
            start <= 1'b0;
        end
        else if (pending_vecs.size() > 0 && !hold_sender && rst_n)
        begin
            start    <= 1'b1;
            sample_0 <= pending_vecs[0].s0;
            sample_1 <= pending_vecs[0].s1;
            sample_2 <= pending_vecs[0].s2;
            sample_3 <= pending_vecs[0].s3;
        end
        else
            start <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        clean_t got, want;
        cycles++;
        if (done)
        begin
            got = '{cleaned_0, cleaned_1, cleaned_2, cleaned_3, fused_average,
                    reliable_mask, replaced_mask};
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $realtime, got);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                checked++;
                if (got.c0 !== want.c0 || got.c1 !== want.c1 || got.c2 !== want.c2
                    || got.c3 !== want.c3)
                begin
                    $display("%0t: cleaned exp %h %h %h %h got %h %h %h %h", $realtime,
                             want.c0, want.c1, want.c2, want.c3,
                             got.c0, got.c1, got.c2, got.c3);
                    errors++;
                end
                if (got.avg !== want.avg)
                begin
                    $display("%0t: fused_average exp %h got %h", $realtime,
                             want.avg, got.avg);
                    errors++;
                end
                if (got.rel !== want.rel || got.rep !== want.rep)
                begin
                    $display("%0t: masks exp %b/%b got %b/%b", $realtime,
                             want.rel, want.rep, got.rel, got.rep);
                    errors++;
                end
            end
        end
        if (cycles > 200000)
        begin
            $display("%0t: timeout", $realtime);
            $display("robust_zscore_outlier_replace: mismatch");
            $finish;
        end
    end

    task automatic reg_write(reg_index_t idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 4'(idx) << 2; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_THRESHOLD:  thr_q = val[11:0];
            REG_MEDIAN_DEV: mad_scale_q = val[15:0];
            REG_MEAN_DEV:   mean_scale_q = val[15:0];
            default: ;
        endcase
    endtask

    task automatic drain_results();
        while (pending_vecs.size() > 0 || expected_results.size() > 0 || start)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    function automatic sample_t rand_reading(int kind);
        case (kind)
            0: return sample_t'($urandom);
            1: return sample_t'($urandom_range(0, 8191)) - 24'sd4096;
            2: return '0;
            default: return 24'sh7FFFFF ^ sample_t'($urandom_range(0, 3) << 22);
        endcase
    endfunction

    task automatic queue_random(int count);
        vec_t v;
        sample_t base;
        for (int k = 0; k < count; k++)
        begin
            base = sample_t'($urandom);
            // mostly clustered readings with an occasional far outlier
            v.s0 = base + sample_t'($urandom_range(0, 255)) - 24'sd128;
            v.s1 = base + sample_t'($urandom_range(0, 255)) - 24'sd128;
            v.s2 = base + sample_t'($urandom_range(0, 255)) - 24'sd128;
            v.s3 = base + sample_t'($urandom_range(0, 255)) - 24'sd128;
            case ($urandom_range(0, 5))
                0: v = vec_t'({$urandom, $urandom, $urandom});
                1: v.s1 = base + sample_t'($urandom_range(0, 65535) << 4);
                2: v = '{rand_reading($urandom_range(0, 3)), rand_reading($urandom_range(0, 3)),
                         rand_reading($urandom_range(0, 3)), rand_reading($urandom_range(0, 3))};
                3: v.s2 = v.s0;
                default: ;
            endcase
            pending_vecs.push_back(v);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // directed corners
        pending_vecs.push_back('{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF});
        pending_vecs.push_back('{24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000});
        pending_vecs.push_back('{24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF});
        pending_vecs.push_back('{24'sh0, 24'sh0, 24'sh0, 24'sh0});
        pending_vecs.push_back('{24'sh1000, 24'sh1000, 24'sh1000, 24'sh7FFFFF});
        pending_vecs.push_back('{24'sh1000, 24'sh1000, 24'sh1001, 24'sh1001});
        pending_vecs.push_back('{24'sh0, 24'sh1, 24'sh2, 24'sh100000});
        pending_vecs.push_back('{-24'sd3, 24'sd0, 24'sd4, -24'sd800000});
        pending_vecs.push_back('{24'sh800000, 24'sh0, 24'sh0, 24'sh0});
        pending_vecs.push_back('{24'sh5, 24'sh5, 24'sh6, 24'sh9});
        drain_results();
        queue_random(250);
        drain_results();
        reg_write(REG_THRESHOLD, 32'h0);
        reg_write(REG_NONE, 32'hFFFF_FFFF);
        pending_vecs.push_back('{24'sh1000, 24'sh1000, 24'sh1000, 24'sh1001});
        queue_random(150);
        drain_results();
        reg_write(REG_THRESHOLD, 32'hFFFF_FFFF);
        reg_write(REG_MEDIAN_DEV, 32'hFFFF_FFFF);
        reg_write(REG_MEAN_DEV, 32'hFFFF_FFFF);
        queue_random(250);
        // pause the sender until everything is back
        repeat (40) @(posedge clk);
        hold_sender = 1'b1;
        while (expected_results.size() > 0 || start) @(posedge clk);
        hold_sender = 1'b0;
        drain_results();
        reg_write(REG_MEDIAN_DEV, 32'h0);
        reg_write(REG_MEAN_DEV, 32'h0);
        reg_write(REG_THRESHOLD, 32'd256);
        queue_random(150);
        drain_results();
        reg_write(REG_MEDIAN_DEV, 32'd4096);
        reg_write(REG_MEAN_DEV, 32'd1);
        reg_write(REG_THRESHOLD, 32'd1);
        queue_random(150);
        drain_results();
        reg_write(REG_THRESHOLD, 32'd896);
        reg_write(REG_MEDIAN_DEV, 32'd6087);
        reg_write(REG_MEAN_DEV, 32'd5134);
        queue_random(200);
        drain_results();
        $display("covered %0d vectors, %0d results checked over six register settings",
                 sent, checked);
        if (errors == 0 && expected_results.size() == 0)
            $display("robust_zscore_outlier_replace: match");
        else
            $display("robust_zscore_outlier_replace: mismatch");
        $finish;
    end
endmodule

### sim.f
src/rzor_pkg.sv
src/rzor_median4.sv
src/rzor_lane.sv
src/robust_zscore_outlier_replace.sv
tb/sv/robust_zscore_outlier_replace_tb.sv
